>>> hdl/ppm_p6_stream_decoder_macros.svh
// Assertion macros for the P6 stream decoder checkers.
`ifndef PPM_P6_STREAM_DECODER_MACROS_SVH
`define PPM_P6_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPMDEC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppm decoder assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PPMDEC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppm decoder assertion failed");

`endif

>>> hdl/ppmdec_pkg.sv
// Shared types, codes and helpers of the P6 stream decoder.
package ppmdec_pkg;

	localparam logic [1:0] ST_PIXEL     = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ST_BAD_HDR   = 2'd2;
	localparam logic [1:0] ST_TRUNC     = 2'd3;

	localparam logic [2:0] PH_MAGIC0 = 3'd0;
	localparam logic [2:0] PH_MAGIC1 = 3'd1;
	localparam logic [2:0] PH_WIDTH  = 3'd2;
	localparam logic [2:0] PH_HEIGHT = 3'd3;
	localparam logic [2:0] PH_MAXV   = 3'd4;
	localparam logic [2:0] PH_PIXELS = 3'd5;
	localparam logic [2:0] PH_IDLE   = 3'd6;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [11:0] NUM_SAT = 12'hFFF;

	// result queue depth
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] rgb;
		logic [10:0] column;
		logic [10:0] row;
		logic [11:0] image_width;
		logic [11:0] image_height;
		logic        end_of_image;
	} ppmdec_result_t;

	// acc*10 + d, saturating at 4095
	function automatic logic [11:0] acc_digit(input logic [11:0] acc, input logic [3:0] d);
		logic [15:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {12'd0, d};
		return (v > {4'd0, NUM_SAT}) ? NUM_SAT : v[11:0];
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
	endfunction

endpackage

>>> hdl/ppm_p6_stream_decoder.sv
// Top level of the P6 pixmap stream decoder.
// A result is written into the queue at the clock edge that ends its byte's transfer.
// Throughput: one byte per cycle while full is low; the parser updates all its state per byte.
// The 4-entry result queue lets the byte side run while results wait; full rises at 4.
// Reset: arst_n clears the parser to expect the first magic byte and empties the queue.
module ppm_p6_stream_decoder import ppmdec_pkg::*; #(
	parameter int MAX_DIM = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_value,
	input  logic        final_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [23:0] rgb,
	output logic [10:0] column,
	output logic [10:0] row,
	output logic [11:0] image_width,
	output logic [11:0] image_height,
	output logic        end_of_image
);

	logic           in_xfer;
	logic           out_xfer;
	logic           res_valid;
	ppmdec_result_t res;
	ppmdec_result_t head;

	assign in_xfer  = push && !full;
	assign out_xfer = pop && !empty;

	ppmdec_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_xfer),
		.byte_value (byte_value),
		.final_byte (final_byte),
		.res_valid  (res_valid),
		.res        (res)
	);

	ppmdec_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (out_xfer),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	assign status       = head.status;
	assign rgb          = head.rgb;
	assign column       = head.column;
	assign row          = head.row;
	assign image_width  = head.image_width;
	assign image_height = head.image_height;
	assign end_of_image = head.end_of_image;

endmodule

>>> hdl/ppmdec_front.sv
// Front end: header parser and pixel packer, one byte per cycle while in_valid is high.
module ppmdec_front import ppmdec_pkg::*; #(
	parameter int MAX_DIM = 2048
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     byte_value,
	input  logic           final_byte,
	output logic           res_valid,
	output ppmdec_result_t res
);

	logic [2:0]  phase_q, phase_d;
	logic [11:0] width_q, width_d;
	logic [11:0] height_q, height_d;
	logic        maxnz_q, maxnz_d;
	logic        digits_q, digits_d;
	logic [11:0] col_q, col_d;
	logic [11:0] row_q, row_d;
	logic [1:0]  slot_q, slot_d;
	logic [15:0] held_q, held_d;

	logic        is_digit;
	logic [3:0]  digit;
	logic        last_col;
	logic        last_row;
	logic        bad_dims;

	assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
	assign digit    = 4'(byte_value - CH_ZERO);
	assign last_col = ({1'b0, col_q} + 13'd1) >= {1'b0, width_q};
	assign last_row = ({1'b0, row_q} + 13'd1) >= {1'b0, height_q};
	assign bad_dims = (width_q == 12'd0) || (height_q == 12'd0) ||
		(width_q > 12'(MAX_DIM)) || (height_q > 12'(MAX_DIM)) || !maxnz_q;

	always_comb begin
		phase_d   = phase_q;
		width_d   = width_q;
		height_d  = height_q;
		maxnz_d   = maxnz_q;
		digits_d  = digits_q;
		col_d     = col_q;
		row_d     = row_q;
		slot_d    = slot_q;
		held_d    = held_q;
		res_valid = 1'b0;
		res       = '0;

		unique case (phase_q) inside
			PH_MAGIC0: begin
				if (byte_value == CH_P) begin
					phase_d = PH_MAGIC1;
				end else begin
					res_valid        = 1'b1;
					res.status       = ST_BAD_MAGIC;
					res.end_of_image = 1'b1;
					phase_d          = PH_IDLE;
				end
			end
			PH_MAGIC1: begin
				if (byte_value == CH_SIX) begin
					phase_d = PH_WIDTH;
				end else begin
					res_valid        = 1'b1;
					res.status       = ST_BAD_MAGIC;
					res.end_of_image = 1'b1;
					phase_d          = PH_IDLE;
				end
			end
			PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
				if (is_digit) begin
					if (phase_q == PH_WIDTH) begin
						width_d = acc_digit(width_q, digit);
					end else if (phase_q == PH_HEIGHT) begin
						height_d = acc_digit(height_q, digit);
					end else if (digit != 4'd0) begin
						maxnz_d = 1'b1;
					end
					digits_d = 1'b1;
				end else if (is_space(byte_value)) begin
					if (digits_q) begin
						digits_d = 1'b0;
						if (phase_q != PH_MAXV) begin
							phase_d = phase_q + 3'd1;
						end else if (bad_dims) begin
							res_valid        = 1'b1;
							res.status       = ST_BAD_HDR;
							res.end_of_image = 1'b1;
							phase_d          = PH_IDLE;
						end else begin
							phase_d = PH_PIXELS;
							col_d   = '0;
							row_d   = '0;
							slot_d  = '0;
						end
					end
				end else begin
					res_valid        = 1'b1;
					res.status       = ST_BAD_HDR;
					res.end_of_image = 1'b1;
					phase_d          = PH_IDLE;
				end
			end
			PH_PIXELS: begin
				if (slot_q != 2'd2) begin
					held_d = {held_q[7:0], byte_value};
					slot_d = slot_q + 2'd1;
				end else begin
					res_valid        = 1'b1;
					res.status       = ST_PIXEL;
					res.rgb          = {held_q, byte_value};
					res.column       = col_q[10:0];
					res.row          = row_q[10:0];
					res.image_width  = width_q;
					res.image_height = height_q;
					res.end_of_image = last_col && last_row;
					slot_d           = '0;
					held_d           = '0;
					if (last_col && last_row) begin
						phase_d = PH_IDLE;
					end else if (last_col) begin
						col_d = '0;
						row_d = row_q + 12'd1;
					end else begin
						col_d = col_q + 12'd1;
					end
				end
			end
			default: begin
			end
		endcase

		if (final_byte) begin
			if (!res_valid && (phase_d != PH_IDLE)) begin
				res_valid        = 1'b1;
				res              = '0;
				res.status       = ST_TRUNC;
				res.end_of_image = 1'b1;
				if (phase_d == PH_PIXELS) begin
					res.image_width  = width_d;
					res.image_height = height_d;
				end
			end
			phase_d  = PH_MAGIC0;
			width_d  = '0;
			height_d = '0;
			maxnz_d  = 1'b0;
			digits_d = 1'b0;
			col_d    = '0;
			row_d    = '0;
			slot_d   = '0;
			held_d   = '0;
		end

		// nothing leaves the parser without a transfer
		if (!in_valid) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC0;
			width_q  <= '0;
			height_q <= '0;
			maxnz_q  <= 1'b0;
			digits_q <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
			held_q   <= '0;
		end else if (in_valid) begin
			phase_q  <= phase_d;
			width_q  <= width_d;
			height_q <= height_d;
			maxnz_q  <= maxnz_d;
			digits_q <= digits_d;
			col_q    <= col_d;
			row_q    <= row_d;
			slot_q   <= slot_d;
			held_q   <= held_d;
		end
	end

endmodule

>>> hdl/ppmdec_fifo.sv
// Result queue between the parser and the result port.
module ppmdec_fifo import ppmdec_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  ppmdec_result_t wr_data,
	input  logic           rd_en,
	output ppmdec_result_t rd_data,
	output logic           full,
	output logic           empty
);

	ppmdec_result_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       count_q;

	assign full    = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/ppmdec_checker.sv
// Port-level checker for the P6 stream decoder, bound to the top level.
`include "ppm_p6_stream_decoder_macros.svh"

module ppmdec_checker import ppmdec_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [23:0] rgb,
	input logic [10:0] column,
	input logic [10:0] row,
	input logic [11:0] image_width,
	input logic [11:0] image_height,
	input logic        end_of_image
);

	// error results close the image and carry no pixel
	`PPMDEC_ASSERT_IMP(a_err_closes, !empty && (status != ST_PIXEL),
		end_of_image && (rgb == 24'd0) && (column == 11'd0) && (row == 11'd0))
	// among the error results, only a truncation inside the pixel data reports the dimensions
	`PPMDEC_ASSERT_IMP(a_err_no_dims,
		!empty && ((status == ST_BAD_MAGIC) || (status == ST_BAD_HDR)),
		(image_width == 12'd0) && (image_height == 12'd0))
	`PPMDEC_ASSERT_NXT(a_head_stays, !empty && !pop, !empty)
	`PPMDEC_ASSERT_NXT(a_head_stable, !empty && !pop,
		$stable(status) && $stable(rgb) && $stable(column) && $stable(row))

endmodule

bind ppm_p6_stream_decoder ppmdec_checker u_ppmdec_checker (.*);
